[rtl/core/bsf_pkg.sv]
package bsf_pkg;

  // Frame geometry.
  localparam int unsigned FrameWords = 18;
  localparam int unsigned IdxW       = 5;
  localparam int unsigned WordW      = 64;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CntW       = 3;

  // Last byte position of each section of the sentence.
  localparam logic [CntW-1:0] HeadLast = 3'd5;
  localparam logic [CntW-1:0] DataLast = 3'd7;
  localparam logic [CntW-1:0] FootLast = 3'd3;

  // Position of the final word of a frame.
  localparam logic [IdxW-1:0] LastIdx = IdxW'(FrameWords - 1);

  // Fixed footer characters.
  localparam logic [ByteW-1:0] StarByte = 8'h2A;
  localparam logic [ByteW-1:0] NulByte  = 8'h00;

  // Queue between the front and the back.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Sequencer phase of the back part.
  typedef enum logic [1:0] {
    BSF_NEW,
    BSF_HEAD,
    BSF_DATA,
    BSF_FOOT
  } bsf_phase_e;

  // One classified word as it travels through the queue.
  typedef struct packed {
    logic [WordW-1:0] word;
    logic             first;
    logic             last;
  } bsf_entry_t;

  // Head of the queue as seen by the back part.
  typedef struct packed {
    logic       valid;
    bsf_entry_t entry;
  } bsf_qhead_t;

  // Header text "$RPCTL", one character per position.
  function automatic logic [ByteW-1:0] head_byte(input logic [CntW-1:0] pos);
    logic [ByteW-1:0] b;
    case (pos)
      3'd0:    b = 8'h24;
      3'd1:    b = 8'h52;
      3'd2:    b = 8'h50;
      3'd3:    b = 8'h43;
      3'd4:    b = 8'h54;
      3'd5:    b = 8'h4C;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Uppercase ASCII hex digit of a nibble.
  function automatic logic [ByteW-1:0] hex_digit(input logic [3:0] nib);
    logic [ByteW-1:0] b;
    if (nib < 4'd10) begin
      b = 8'h30 + {4'h0, nib};
    end else begin
      b = 8'h37 + {4'h0, nib};
    end
    return b;
  endfunction

endpackage

[rtl/core/bsf_front.sv]
module bsf_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [bsf_pkg::WordW-1:0] word_value_i,
  output bsf_pkg::bsf_entry_t       entry_o
);

  logic [bsf_pkg::IdxW-1:0] word_index_q, word_index_d;
  logic                     first, last;

  // Classify the word by its place in the frame.
  assign first = (word_index_q == '0);
  assign last  = (word_index_q >= bsf_pkg::LastIdx);

  assign entry_o.word  = word_value_i;
  assign entry_o.first = first;
  assign entry_o.last  = last;

  // The word counter wraps after the final word of a frame.
  always_comb begin
    word_index_d = word_index_q;
    if (accept_i) begin
      word_index_d = last ? '0 : word_index_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_index_q <= '0;
    end else begin
      word_index_q <= word_index_d;
    end
  end

endmodule

[rtl/core/bsf_queue.sv]
module bsf_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  bsf_pkg::bsf_entry_t wr_entry_i,
  output logic                full_o,
  input  logic                rd_i,
  output bsf_pkg::bsf_qhead_t head_o
);

  bsf_pkg::bsf_entry_t              mem_q [bsf_pkg::QDepth];
  logic [bsf_pkg::QPtrW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [bsf_pkg::QCntW-1:0]        count_q, count_d;

  assign full_o       = (count_q == bsf_pkg::QCntW'(bsf_pkg::QDepth));
  assign head_o.valid = (count_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];

  // Occupancy follows pushes and pops.
  always_comb begin
    count_d = count_q;
    case ({wr_i, rd_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

endmodule

[rtl/core/bsf_back.sv]
module bsf_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bsf_pkg::bsf_qhead_t       head_i,
  output logic                      rd_o,
  output logic                      empty,
  input  logic                      pop,
  output logic [bsf_pkg::ByteW-1:0] out_byte_o,
  output logic                      run_last_o,
  output logic                      frame_end_o
);

  bsf_pkg::bsf_phase_e      state_q, state_d, eff_phase;
  logic [bsf_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [bsf_pkg::ByteW-1:0] xor_q, xor_d;
  logic [bsf_pkg::ByteW-1:0] byte_c;
  logic                      run_last_c, frame_end_c, word_done;
  logic                      footer, adv, emit;
  logic                      out_valid_q;
  logic [bsf_pkg::ByteW-1:0] out_byte_q;
  logic                      run_last_q, frame_end_q;

  // A word starts with the header only when it opens a frame, and gets the
  // footer only when it closes one; a frame of a single word drops it.
  assign footer    = head_i.entry.last && !head_i.entry.first;
  assign eff_phase = (state_q == bsf_pkg::BSF_NEW) ?
                     (head_i.entry.first ? bsf_pkg::BSF_HEAD : bsf_pkg::BSF_DATA) :
                     state_q;

  // A byte is produced whenever work waits and the output register is free or being popped.
  assign adv  = !out_valid_q || pop;
  assign emit = head_i.valid && adv;
  assign rd_o = emit && word_done;

  // Next phase and byte position.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    if (emit) begin
      case (eff_phase)
        bsf_pkg::BSF_HEAD: begin
          if (cnt_q == bsf_pkg::HeadLast) begin
            state_d = bsf_pkg::BSF_DATA;
            cnt_d   = '0;
          end else begin
            state_d = bsf_pkg::BSF_HEAD;
            cnt_d   = cnt_q + 1'b1;
          end
        end
        bsf_pkg::BSF_DATA: begin
          if (cnt_q == bsf_pkg::DataLast) begin
            state_d = footer ? bsf_pkg::BSF_FOOT : bsf_pkg::BSF_NEW;
            cnt_d   = '0;
          end else begin
            state_d = bsf_pkg::BSF_DATA;
            cnt_d   = cnt_q + 1'b1;
          end
        end
        bsf_pkg::BSF_FOOT: begin
          if (cnt_q == bsf_pkg::FootLast) begin
            state_d = bsf_pkg::BSF_NEW;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        default: begin
          state_d = state_q;
        end
      endcase
    end
  end

  // Byte value, flags and checksum update for the current position.
  always_comb begin
    byte_c      = bsf_pkg::NulByte;
    run_last_c  = 1'b0;
    frame_end_c = 1'b0;
    word_done   = 1'b0;
    xor_d       = xor_q;
    case (eff_phase)
      bsf_pkg::BSF_HEAD: begin
        byte_c = bsf_pkg::head_byte(cnt_q);
        // The leading dollar sign is not part of the checksum.
        xor_d  = (cnt_q == '0) ? '0 : (xor_q ^ byte_c);
      end
      bsf_pkg::BSF_DATA: begin
        byte_c = head_i.entry.word[{cnt_q, 3'b000} +: bsf_pkg::ByteW];
        xor_d  = xor_q ^ byte_c;
        if ((cnt_q == bsf_pkg::DataLast) && !footer) begin
          run_last_c = 1'b1;
          word_done  = 1'b1;
        end
      end
      bsf_pkg::BSF_FOOT: begin
        case (cnt_q)
          3'd0:    byte_c = bsf_pkg::StarByte;
          3'd1:    byte_c = bsf_pkg::hex_digit(xor_q[7:4]);
          3'd2:    byte_c = bsf_pkg::hex_digit(xor_q[3:0]);
          default: begin
            byte_c      = bsf_pkg::NulByte;
            run_last_c  = 1'b1;
            frame_end_c = 1'b1;
            word_done   = 1'b1;
            xor_d       = '0;
          end
        endcase
      end
      default: begin
        byte_c = bsf_pkg::NulByte;
      end
    endcase
  end

  // Output register: one byte held until it is popped.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q  <= byte_c;
      run_last_q  <= run_last_c;
      frame_end_q <= frame_end_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsf_pkg::BSF_NEW;
      cnt_q       <= '0;
      xor_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (emit) begin
        xor_q <= xor_d;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign empty       = !out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = run_last_q;
  assign frame_end_o = frame_end_q;

`ifndef ASSERT_OFF
  // The terminating zero byte always closes the run of its word.
  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && frame_end_o) |-> run_last_o)
    else $error("frame end byte without run end");

  // The footer is only entered for a word that closes a frame.
  a_foot_has_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bsf_pkg::BSF_FOOT) |-> (head_i.valid && footer))
    else $error("footer phase without a closing word");

  // Mid-word positions always belong to a word still in the queue.
  a_mid_word_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != bsf_pkg::BSF_NEW) |-> head_i.valid)
    else $error("sequencer mid-word with queue empty");

  // A word leaves the queue only on its final byte, which restarts the phase.
  a_pop_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_o |=> (state_q == bsf_pkg::BSF_NEW) && (cnt_q == '0))
    else $error("word left the queue before its last byte");
`endif

endmodule

[rtl/core/binary_sentence_framer_top.sv]
// Channel  Direction  Handshake          Payload
// input    in         push / full        word_value_i (64 bits, unsigned)
// result   out        empty / pop        out_byte_o, run_last_o, frame_end_o
//
// Each result word is one byte, produced at one byte per cycle by the back
// sequencer into a single output register while pops keep it free; a middle
// word gives its data bytes, a frame's first adds the header, its last the footer.
// Asynchronous active-low reset clears the word counter, the two-word queue,
// the sequencer and the output valid flag; there is no clearing pass.
// Words are accepted while the queue has room, also while a byte waits to be
// popped; a stalled pop holds the byte and eventually fills the queue.
module binary_sentence_framer_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [63:0]               word_value_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [7:0]                out_byte_o,
  output logic                      run_last_o,
  output logic                      frame_end_o
);

  bsf_pkg::bsf_entry_t entry;
  bsf_pkg::bsf_qhead_t head;
  logic                accept;
  logic                rd;

  assign accept = push && !full;

  // Front: counts words in the frame and classifies each one.
  bsf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .word_value_i (word_value_i),
    .entry_o      (entry)
  );

  // Queue between the two sides.
  bsf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (accept),
    .wr_entry_i (entry),
    .full_o     (full),
    .rd_i       (rd),
    .head_o     (head)
  );

  // Back: turns each queued word into its bytes.
  bsf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .rd_o        (rd),
    .empty       (empty),
    .pop         (pop),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .frame_end_o (frame_end_o)
  );

endmodule
